FILE: rtl/core/sep_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the setpoint entry parser.
// No dependencies.
package sep_pkg;

  localparam int SEP_BUF_LEN = 16;

  localparam int SP_W    = 16;
  localparam int CHAR_W  = 8;
  localparam int CAUSE_W = 2;
  localparam int IDX_W   = 8;
  localparam int MAG_W   = 16;

  typedef logic signed [SP_W-1:0] sp_t;
  typedef logic [CHAR_W-1:0]      char_t;
  typedef logic [CAUSE_W-1:0]     cause_t;
  typedef logic [IDX_W-1:0]       reg_idx_t;

  localparam cause_t CAUSE_SERIAL = 2'd0;
  localparam cause_t CAUSE_COMMIT = 2'd1;
  localparam cause_t CAUSE_NUDGE  = 2'd2;

  localparam reg_idx_t REG_SETPOINT_MIN   = 8'd0;
  localparam reg_idx_t REG_SETPOINT_MAX   = 8'd1;
  localparam reg_idx_t REG_KEY_CLEAR      = 8'd2;
  localparam reg_idx_t REG_KEY_COMMIT     = 8'd3;
  localparam reg_idx_t REG_KEY_UP_SMALL   = 8'd4;
  localparam reg_idx_t REG_KEY_DOWN_SMALL = 8'd5;
  localparam reg_idx_t REG_KEY_UP_LARGE   = 8'd6;
  localparam reg_idx_t REG_KEY_DOWN_LARGE = 8'd7;

  localparam char_t CH_LF    = 8'h0A;
  localparam char_t CH_CR    = 8'h0D;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_TAB   = 8'h09;
  localparam char_t CH_VT    = 8'h0B;
  localparam char_t CH_FF    = 8'h0C;
  localparam char_t CH_PLUS  = 8'h2B;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_NINE  = 8'h39;

  localparam sp_t   RST_SETPOINT       = 16'sd250;
  localparam sp_t   RST_SETPOINT_MIN   = -16'sd400;
  localparam sp_t   RST_SETPOINT_MAX   = 16'sd1250;
  localparam char_t RST_KEY_CLEAR      = 8'd42;
  localparam char_t RST_KEY_COMMIT     = 8'd35;
  localparam char_t RST_KEY_UP_SMALL   = 8'd65;
  localparam char_t RST_KEY_DOWN_SMALL = 8'd66;
  localparam char_t RST_KEY_UP_LARGE   = 8'd67;
  localparam char_t RST_KEY_DOWN_LARGE = 8'd68;

  localparam int NUDGE_SMALL = 10;
  localparam int NUDGE_LARGE = 100;

endpackage

FILE: rtl/core/sep_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the setpoint entry parser: characters, results, register writes.
// Depends on sep_pkg.
interface sep_char_if;
  logic                 valid;
  logic                 ready;
  logic                 func;
  sep_pkg::char_t       char_code;
  modport source (output valid, func, char_code, input ready);
  modport sink   (input valid, func, char_code, output ready);
endinterface

interface sep_result_if;
  logic                 valid;
  logic                 ready;
  sep_pkg::sp_t         new_setpoint;
  sep_pkg::cause_t      cause;
  modport source (output valid, new_setpoint, cause, input ready);
  modport sink   (input valid, new_setpoint, cause, output ready);
endinterface

interface sep_cfg_if;
  logic                 valid;
  logic                 ready;
  sep_pkg::reg_idx_t    index;
  logic [15:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/setpoint_entry_parser.sv
`timescale 1ns / 1ps
// Setpoint entry parser top level: serial line checker, keypad entry, clamped setpoint.
// Depends on sep_pkg and the interfaces in sep_if.
//
//  channel  | modport | payload                     | handshake
//  chars    | sink    | func, char_code             | valid/ready
//  result   | source  | new_setpoint, cause         | valid/ready
//  cfg      | sink    | index, data                 | valid/ready, ready tied high
//
// One item a cycle: each character is decoded and the setpoint updated in the
// cycle it is accepted; its result sits in the output register the next cycle.
// The setpoint register feeds back into the next item, which is what bounds this rate.
// A stalled result blocks further items only while it waits; reset is synchronous.
module setpoint_entry_parser #(
  parameter int BUF_LEN = sep_pkg::SEP_BUF_LEN
) (
  input  logic         clk,
  input  logic         rst,
  sep_char_if.sink     chars,
  sep_result_if.source result,
  sep_cfg_if.sink      cfg
);

  localparam int CNT_W = (BUF_LEN > 2) ? $clog2(BUF_LEN) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(BUF_LEN - 1);
  localparam int VAL_W = 22;

  typedef enum logic [1:0] {PH_WS, PH_SIGN, PH_DIGITS, PH_BAD} phase_t;
  typedef logic [sep_pkg::MAG_W-1:0] mag_t;
  typedef logic signed [VAL_W-1:0] val_t;

  function automatic mag_t add_digit(mag_t mag, logic [3:0] d);
    logic [19:0] m;
    m = 20'({mag, 3'b000}) + 20'({mag, 1'b0}) + 20'(d);
    return (|m[19:16]) ? '1 : m[15:0];
  endfunction

  function automatic val_t times_ten(mag_t mag);
    return val_t'({mag, 3'b000}) + val_t'({mag, 1'b0});
  endfunction

  sep_pkg::sp_t   setpoint_min, setpoint_max;
  sep_pkg::char_t key_clear, key_commit, key_up_small, key_down_small;
  sep_pkg::char_t key_up_large, key_down_large;

  sep_pkg::sp_t     setpoint, setpoint_next;
  mag_t             serial_magnitude, serial_magnitude_next;
  logic [CNT_W-1:0] serial_count, serial_count_next;
  phase_t           serial_phase, serial_phase_next;
  logic             serial_negative, serial_negative_next;
  mag_t             keypad_magnitude, keypad_magnitude_next;
  logic [CNT_W-1:0] keypad_count, keypad_count_next;

  logic            accept, emit;
  sep_pkg::cause_t emit_cause;
  val_t            cand;
  sep_pkg::char_t  c;
  logic            is_digit, is_blank;

  assign chars.ready = !result.valid || result.ready;
  assign cfg.ready   = 1'b1;
  assign accept      = chars.valid && chars.ready;
  assign c           = chars.char_code;
  assign is_digit    = (c >= sep_pkg::CH_ZERO) && (c <= sep_pkg::CH_NINE);
  assign is_blank    = (c == sep_pkg::CH_SPACE) || (c == sep_pkg::CH_TAB) ||
                       (c == sep_pkg::CH_VT) || (c == sep_pkg::CH_FF);

  always_comb begin
    serial_magnitude_next = serial_magnitude;
    serial_count_next     = serial_count;
    serial_phase_next     = serial_phase;
    serial_negative_next  = serial_negative;
    keypad_magnitude_next = keypad_magnitude;
    keypad_count_next     = keypad_count;
    emit                  = 1'b0;
    emit_cause            = sep_pkg::CAUSE_SERIAL;
    cand                  = val_t'(setpoint);
    if (!chars.func) begin
      if (c == sep_pkg::CH_LF || c == sep_pkg::CH_CR) begin
        if (serial_count != '0) begin
          if (serial_phase == PH_DIGITS) begin
            emit = 1'b1;
            cand = serial_negative ? -times_ten(serial_magnitude)
                                   : times_ten(serial_magnitude);
          end
          serial_magnitude_next = '0;
          serial_count_next     = '0;
          serial_phase_next     = PH_WS;
          serial_negative_next  = 1'b0;
        end
      end else if (serial_count < CNT_MAX) begin
        serial_count_next = serial_count + 1'b1;
        unique case (serial_phase)
          PH_WS: begin
            if (is_blank) begin
              serial_phase_next = PH_WS;
            end else if (c == sep_pkg::CH_PLUS || c == sep_pkg::CH_MINUS) begin
              serial_negative_next = (c == sep_pkg::CH_MINUS);
              serial_phase_next    = PH_SIGN;
            end else if (is_digit) begin
              serial_magnitude_next = mag_t'(c[3:0]);
              serial_phase_next     = PH_DIGITS;
            end else begin
              serial_phase_next = PH_BAD;
            end
          end
          PH_SIGN: begin
            if (is_digit) begin
              serial_magnitude_next = mag_t'(c[3:0]);
              serial_phase_next     = PH_DIGITS;
            end else begin
              serial_phase_next = PH_BAD;
            end
          end
          PH_DIGITS: begin
            if (is_digit) serial_magnitude_next = add_digit(serial_magnitude, c[3:0]);
            else serial_phase_next = PH_BAD;
          end
          PH_BAD: serial_phase_next = PH_BAD;
        endcase
      end
    end else begin
      emit_cause = sep_pkg::CAUSE_NUDGE;
      if (is_digit) begin
        if (keypad_count < CNT_MAX) begin
          keypad_magnitude_next = add_digit(keypad_magnitude, c[3:0]);
          keypad_count_next     = keypad_count + 1'b1;
        end
      end else if (c == key_clear) begin
        keypad_magnitude_next = '0;
        keypad_count_next     = '0;
      end else if (c == key_commit) begin
        if (keypad_count != '0) begin
          emit                  = 1'b1;
          emit_cause            = sep_pkg::CAUSE_COMMIT;
          cand                  = times_ten(keypad_magnitude);
          keypad_magnitude_next = '0;
          keypad_count_next     = '0;
        end
      end else if (c == key_up_small) begin
        emit = 1'b1;
        cand = val_t'(setpoint) + val_t'(sep_pkg::NUDGE_SMALL);
      end else if (c == key_down_small) begin
        emit = 1'b1;
        cand = val_t'(setpoint) - val_t'(sep_pkg::NUDGE_SMALL);
      end else if (c == key_up_large) begin
        emit = 1'b1;
        cand = val_t'(setpoint) + val_t'(sep_pkg::NUDGE_LARGE);
      end else if (c == key_down_large) begin
        emit = 1'b1;
        cand = val_t'(setpoint) - val_t'(sep_pkg::NUDGE_LARGE);
      end
    end
    if (!emit) begin
      setpoint_next = setpoint;
    end else if (cand < val_t'(setpoint_min)) begin
      setpoint_next = setpoint_min;
    end else if (cand > val_t'(setpoint_max)) begin
      setpoint_next = setpoint_max;
    end else begin
      setpoint_next = sep_pkg::sp_t'(cand);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint_min     <= sep_pkg::RST_SETPOINT_MIN;
      setpoint_max     <= sep_pkg::RST_SETPOINT_MAX;
      key_clear        <= sep_pkg::RST_KEY_CLEAR;
      key_commit       <= sep_pkg::RST_KEY_COMMIT;
      key_up_small     <= sep_pkg::RST_KEY_UP_SMALL;
      key_down_small   <= sep_pkg::RST_KEY_DOWN_SMALL;
      key_up_large     <= sep_pkg::RST_KEY_UP_LARGE;
      key_down_large   <= sep_pkg::RST_KEY_DOWN_LARGE;
      setpoint         <= sep_pkg::RST_SETPOINT;
      serial_magnitude <= '0;
      serial_count     <= '0;
      serial_phase     <= PH_WS;
      serial_negative  <= 1'b0;
      keypad_magnitude <= '0;
      keypad_count     <= '0;
      result.valid     <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          sep_pkg::REG_SETPOINT_MIN:   setpoint_min   <= cfg.data;
          sep_pkg::REG_SETPOINT_MAX:   setpoint_max   <= cfg.data;
          sep_pkg::REG_KEY_CLEAR:      key_clear      <= cfg.data[7:0];
          sep_pkg::REG_KEY_COMMIT:     key_commit     <= cfg.data[7:0];
          sep_pkg::REG_KEY_UP_SMALL:   key_up_small   <= cfg.data[7:0];
          sep_pkg::REG_KEY_DOWN_SMALL: key_down_small <= cfg.data[7:0];
          sep_pkg::REG_KEY_UP_LARGE:   key_up_large   <= cfg.data[7:0];
          sep_pkg::REG_KEY_DOWN_LARGE: key_down_large <= cfg.data[7:0];
          default: ;
        endcase
      end
      if (accept) begin
        setpoint         <= setpoint_next;
        serial_magnitude <= serial_magnitude_next;
        serial_count     <= serial_count_next;
        serial_phase     <= serial_phase_next;
        serial_negative  <= serial_negative_next;
        keypad_magnitude <= keypad_magnitude_next;
        keypad_count     <= keypad_count_next;
      end
      if (accept && emit) begin
        result.valid        <= 1'b1;
        result.new_setpoint <= setpoint_next;
        result.cause        <= emit_cause;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

endmodule
